### design/aitp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitp_pkg
// shared types and constants of the ascii integer token parser
// ----------------------------------------------------------------------------
package aitp_pkg;

    // field widths
    localparam int CH_W   = 8;
    localparam int VAL_W  = 64;
    localparam int LEN_W  = 8;
    localparam int DIG_W  = 4;
    localparam int FMT_W  = 2;
    // output tdata: ok, value, length, padded to whole bytes
    localparam int OUT_RAW_W = 1 + VAL_W + LEN_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

    // length saturates at min(MAX_LENGTH, 255)
    localparam int MAX_LENGTH = 255;
    localparam int LEN_CAP_I  = (MAX_LENGTH < 255) ? MAX_LENGTH : 255;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

    // number formats
    localparam logic [FMT_W-1:0] FMT_UDEC = 2'd0;
    localparam logic [FMT_W-1:0] FMT_SDEC = 2'd1;
    localparam logic [FMT_W-1:0] FMT_HEX  = 2'd2;

    // queue between front and back (power of two depth)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // character class found by the front
    typedef enum logic [5:0] {
        K_DIGIT = 6'b000001,
        K_HEXL  = 6'b000010,
        K_PLUS  = 6'b000100,
        K_MINUS = 6'b001000,
        K_X     = 6'b010000,
        K_OTHER = 6'b100000
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic [DIG_W-1:0] dval;
    } t_item;

    // queue head as seen by the back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // position inside the token
    typedef enum logic [2:0] {
        PH_START  = 3'b001,
        PH_PREFIX = 3'b010,
        PH_BODY   = 3'b100
    } t_phase;

endpackage
`default_nettype wire

### design/ascii_integer_token_parser_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_integer_token_parser_core
// parses number tokens from a character stream into 64-bit values
// ----------------------------------------------------------------------------
// usage
//   slave side takes one character per request in s_tdata[7:0]. a token ends
//   at the first character outside the set of the current format; that
//   character is consumed as well and causes one result request on the master
//   side: tdata[0] ok, [64:1] value, [72:65] length, upper bits zero.
//   accepted token characters give no result.
//   the format register (0 unsigned, 1 signed, 2 0x hex, 3 as unsigned) is
//   written on the cfg channel, which is always ready; a write drops any
//   token in progress and is expected only while the block is idle.
//   throughput: one character per cycle while the queue has room; the
//   multiply-by-ten accumulate in the back part is combinational.
//   result path: a terminator is written into the two-entry queue when it is
//   taken and moved from there into the result register once that register
//   is free or being read.
//   reset: synchronous, active low; format returns to unsigned decimal,
//   the queue and result register empty.
//   stall: with the master stalled, the queue still takes token characters;
//   a second terminator waits in the queue, and s_tready drops once both
//   entries are full.
// ----------------------------------------------------------------------------
module ascii_integer_token_parser_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [aitp_pkg::CH_W-1:0]     i_s_tdata,   // [7:0] ch
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [aitp_pkg::OUT_W-1:0]         o_m_tdata,   // [0] ok, [64:1] value, [72:65] length
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [aitp_pkg::FMT_W-1:0]    i_cfg_data   // [1:0] number_format
);
    import aitp_pkg::*;

    t_qhead w_head;
    logic   w_pop;

    assign o_cfg_ready = 1'b1;

    // front: classify and queue
    aitp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // back: token state and result
    aitp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    // checks
    a_pop_needs_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

    a_fail_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata[OUT_W-1:1] == '0))
        else $error("failed token carries nonzero value or length");

    a_ok_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> (o_m_tdata[VAL_W+LEN_W:VAL_W+1] != '0))
        else $error("valid token with zero length");

endmodule
`default_nettype wire

### design/aitp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitp_front
// accepts characters, classifies them and queues them for the back
// ----------------------------------------------------------------------------
module aitp_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [aitp_pkg::CH_W-1:0] i_s_tdata,  // [7:0] ch
    output aitp_pkg::t_qhead             o_head,
    input  wire logic                    i_pop
);
    import aitp_pkg::*;

    localparam logic [CH_W-1:0] CH_0     = 8'h30;
    localparam logic [CH_W-1:0] CH_9     = 8'h39;
    localparam logic [CH_W-1:0] CH_A     = 8'h61;
    localparam logic [CH_W-1:0] CH_F     = 8'h66;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CH_W-1:0] CH_X     = 8'h78;
    localparam logic [CH_W-1:0] HEXL_OFS = 8'h57;

    t_item              w_item;
    logic [CH_W-1:0]    w_diff;
    logic               w_push;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr, n_wptr;
    logic [QPTR_W-1:0]  r_rptr, n_rptr;
    logic [QCNT_W-1:0]  r_count, n_count;

    // character classification
    always_comb begin
        w_item.kind = K_OTHER;
        w_item.dval = '0;
        w_diff      = '0;
        priority if (i_s_tdata >= CH_0 && i_s_tdata <= CH_9) begin
            w_item.kind = K_DIGIT;
            w_diff      = i_s_tdata - CH_0;
            w_item.dval = w_diff[DIG_W-1:0];
        end else if (i_s_tdata >= CH_A && i_s_tdata <= CH_F) begin
            w_item.kind = K_HEXL;
            w_diff      = i_s_tdata - HEXL_OFS;
            w_item.dval = w_diff[DIG_W-1:0];
        end else if (i_s_tdata == CH_PLUS) begin
            w_item.kind = K_PLUS;
        end else if (i_s_tdata == CH_MINUS) begin
            w_item.kind = K_MINUS;
        end else if (i_s_tdata == CH_X) begin
            w_item.kind = K_X;
        end else begin
            w_item.kind = K_OTHER;
        end
    end

    // queue control
    assign o_s_tready = (r_count != QCNT_W'(QDEPTH));
    assign w_push     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_wptr  = w_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + QCNT_W'(w_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= w_item;
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_mem[r_rptr];

endmodule
`default_nettype wire

### design/aitp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// aitp_back
// token state, digit accumulation and the result register
// ----------------------------------------------------------------------------
module aitp_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_valid,
    input  wire logic [aitp_pkg::FMT_W-1:0]  i_cfg_data,
    input  wire aitp_pkg::t_qhead            i_head,
    output logic                             o_pop,
    output logic                             o_m_tvalid,
    input  wire logic                        i_m_tready,
    output logic [aitp_pkg::OUT_W-1:0]       o_m_tdata  // [0] ok, [64:1] value, [72:65] length
);
    import aitp_pkg::*;

    localparam int ACC_W = VAL_W + 4;

    logic [FMT_W-1:0]  r_format;
    t_phase            r_phase, n_phase;
    logic [VAL_W-1:0]  r_mag, n_mag;
    logic              r_neg, n_neg;
    logic              r_ovf, n_ovf;
    logic              r_bad, n_bad;
    logic              r_seen, n_seen;
    logic [LEN_W-1:0]  r_cnt, n_cnt;

    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [VAL_W-1:0]  r_out_val, n_out_val;
    logic [LEN_W-1:0]  r_out_len, n_out_len;

    logic [ACC_W-1:0]  w_dec;
    logic [VAL_W-1:0]  w_hex;
    logic              w_is_hex, w_is_sdec;
    logic              w_take, w_add_dec, w_add_hex;
    logic              w_out_free, w_ok;
    logic [VAL_W-1:0]  w_val;

    assign w_is_hex  = (r_format == FMT_HEX);
    assign w_is_sdec = (r_format == FMT_SDEC);

    // multiply-accumulate by ten and shift-in by sixteen
    assign w_dec = ({4'b0, r_mag} << 3) + ({4'b0, r_mag} << 1)
                 + ACC_W'(i_head.item.dval);
    assign w_hex = {r_mag[VAL_W-5:0], i_head.item.dval};

    // does the head character belong to the token
    always_comb begin
        w_take    = 1'b0;
        w_add_dec = 1'b0;
        w_add_hex = 1'b0;
        if (w_is_hex) begin
            unique case (r_phase)
                PH_START: begin
                    w_take = (i_head.item.kind == K_DIGIT) && (i_head.item.dval == '0);
                end
                PH_PREFIX: begin
                    w_take = (i_head.item.kind == K_X);
                end
                PH_BODY: begin
                    w_add_hex = (i_head.item.kind == K_DIGIT) || (i_head.item.kind == K_HEXL);
                    w_take    = w_add_hex;
                end
                default: w_take = 1'b0;
            endcase
        end else begin
            w_add_dec = (i_head.item.kind == K_DIGIT);
            w_take    = w_add_dec || (w_is_sdec &&
                        (i_head.item.kind == K_PLUS || i_head.item.kind == K_MINUS));
        end
    end

    // final check and sign handling at the terminator
    always_comb begin
        w_ok  = r_seen && !r_bad && !r_ovf;
        w_val = r_mag;
        if (w_is_sdec) begin
            if (r_neg) begin
                if (r_mag[VAL_W-1] && (r_mag[VAL_W-2:0] != '0)) begin
                    w_ok = 1'b0;
                end
                w_val = '0 - r_mag;
            end else if (r_mag[VAL_W-1]) begin
                w_ok = 1'b0;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_m_tready;

    // token state and result register update
    always_comb begin
        n_phase     = r_phase;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_ovf       = r_ovf;
        n_bad       = r_bad;
        n_seen      = r_seen;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_ok    = r_out_ok;
        n_out_val   = r_out_val;
        n_out_len   = r_out_len;
        o_pop       = 1'b0;
        priority if (i_cfg_valid) begin
            // a format write abandons the token
            n_phase = PH_START;
            n_mag   = '0;
            n_neg   = 1'b0;
            n_ovf   = 1'b0;
            n_bad   = 1'b0;
            n_seen  = 1'b0;
            n_cnt   = '0;
        end else if (i_head.valid && w_take) begin
            o_pop = 1'b1;
            if (r_cnt != LEN_CAP) begin
                n_cnt = r_cnt + 1'b1;
            end
            if (w_is_hex) begin
                if (r_phase == PH_START) begin
                    n_phase = PH_PREFIX;
                end else if (r_phase == PH_PREFIX) begin
                    n_phase = PH_BODY;
                end
            end else begin
                n_phase = PH_BODY;
            end
            if (w_add_dec) begin
                n_seen = 1'b1;
                if (!r_ovf) begin
                    if (w_dec[ACC_W-1:VAL_W] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = w_dec[VAL_W-1:0];
                    end
                end
            end else if (w_add_hex) begin
                n_seen = 1'b1;
                if (!r_ovf) begin
                    if (r_mag[VAL_W-1:VAL_W-4] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_mag = w_hex;
                    end
                end
            end else if (r_phase == PH_START) begin
                n_neg = (i_head.item.kind == K_MINUS);
            end else if (!w_is_hex) begin
                n_bad = 1'b1;
            end
        end else if (i_head.valid && w_out_free) begin
            // terminator: emit one result and start a new token
            o_pop       = 1'b1;
            n_out_valid = 1'b1;
            n_out_ok    = w_ok;
            n_out_val   = w_ok ? w_val : '0;
            n_out_len   = w_ok ? r_cnt : '0;
            n_phase     = PH_START;
            n_mag       = '0;
            n_neg       = 1'b0;
            n_ovf       = 1'b0;
            n_bad       = 1'b0;
            n_seen      = 1'b0;
            n_cnt       = '0;
        end else begin
            o_pop = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format    <= FMT_UDEC;
            r_phase     <= PH_START;
            r_mag       <= '0;
            r_neg       <= 1'b0;
            r_ovf       <= 1'b0;
            r_bad       <= 1'b0;
            r_seen      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_format <= i_cfg_data;
            end
            r_phase     <= n_phase;
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_ovf       <= n_ovf;
            r_bad       <= n_bad;
            r_seen      <= n_seen;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_ok  <= n_out_ok;
        r_out_val <= n_out_val;
        r_out_len <= n_out_len;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'({r_out_len, r_out_val, r_out_ok});

endmodule
`default_nettype wire
